@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is high
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert a property on the rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/rbdc_pkg.sv @@
// Shared constants, types and helper functions of the RGB565 Bayer dither and clip block
package rbdc_pkg;

  localparam int MAX_TILE_SIDE = 256;
  localparam int CNT_W = $clog2(MAX_TILE_SIDE);
  localparam int SIDE_W = CNT_W + 1;

  localparam int COORD_W = 11;
  localparam int SIDE_FIELD_W = 9;
  localparam int COLOR_W = 16;
  localparam int SCREEN_W = 12;
  localparam int SUM_W = 13;
  localparam int CMP_W = (SIDE_FIELD_W > SIDE_W) ? SIDE_FIELD_W : SIDE_W;

  localparam int IN_W = 56;
  localparam int OUT_W = 24;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [SCREEN_W-1:0] SCREEN_LIMIT = 12'd2048;
  localparam logic [COORD_W-1:0] TARGET_X_RESET = 11'd0;
  localparam logic [COORD_W-1:0] TARGET_Y_RESET = 11'd0;
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET = 12'd800;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

  // gray = sum / 3 as (sum * 683) >> 11, exact for sums up to 748
  localparam int GRAY_SUM_W = 10;
  localparam int GRAY_MUL_W = 11;
  localparam int GRAY_PROD_W = GRAY_SUM_W + GRAY_MUL_W;
  localparam logic [GRAY_MUL_W-1:0] GRAY_MUL = 11'd683;
  localparam int GRAY_SHIFT = 11;
  localparam int GRAY_W = 8;

  typedef enum logic [1:0] {
    REG_TARGET_X      = 2'd0,
    REG_TARGET_Y      = 2'd1,
    REG_SCREEN_WIDTH  = 2'd2,
    REG_SCREEN_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic [GRAY_W-1:0] BAYER [4][4] = '{
    '{8'd15,  8'd135, 8'd45,  8'd165},
    '{8'd195, 8'd75,  8'd225, 8'd105},
    '{8'd60,  8'd180, 8'd30,  8'd150},
    '{8'd240, 8'd120, 8'd210, 8'd90}
  };

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_FIELD_W-1:0] f);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(f);
    if (f == '0) begin
      return SIDE_W'(1);
    end else if (wide > CMP_W'(MAX_TILE_SIDE)) begin
      return SIDE_W'(MAX_TILE_SIDE);
    end else begin
      return SIDE_W'(wide);
    end
  endfunction

  function automatic logic [SCREEN_W-1:0] clamp_screen(input logic [SCREEN_W-1:0] v);
    return (v > SCREEN_LIMIT) ? SCREEN_LIMIT : v;
  endfunction

endpackage

@@ design/rgb565_bayer_dither_clip.sv @@
// Top level: places RGB565 tile pixels on screen, clips them and reduces each to one bit
// One pixel request is taken every clock while s_tready is high; an accepted request
// sits in the input register and moves to the result register, which drives m_tvalid,
// when that register next loads. A full output only holds the pipe while m_tready is low.
// Pixels of each tile arrive in
// row-major order; column and row counters inside the block place each pixel at
// target + tile origin + counter. Pixels at or past the screen size give no result.
// Kept pixels become gray = (8r + 4g + 8b) / 3 and are white when gray exceeds the
// 4x4 Bayer threshold picked by the low two bits of the screen row and column.
// Write the registers only while no request is in flight.
module rgb565_bayer_dither_clip (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // tile_x[10:0], tile_y[21:11], tile_width[30:22], tile_height[39:31], pixel_color[55:40]
  input  logic [rbdc_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // screen_x[10:0], screen_y[21:11], is_white[22], zero[23]
  output logic [rbdc_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbdc_pkg::ADDR_W-1:0] paddr,
  input  logic [rbdc_pkg::DATA_W-1:0] pwdata,
  output logic [rbdc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic [rbdc_pkg::COORD_W-1:0]  target_x;
  logic [rbdc_pkg::COORD_W-1:0]  target_y;
  logic [rbdc_pkg::SCREEN_W-1:0] screen_width;
  logic [rbdc_pkg::SCREEN_W-1:0] screen_height;
  logic                          cfg_wr;
  rbdc_pkg::reg_idx_t            reg_idx;

  logic [rbdc_pkg::COORD_W-1:0]      in_tile_x;
  logic [rbdc_pkg::COORD_W-1:0]      in_tile_y;
  logic [rbdc_pkg::SIDE_FIELD_W-1:0] in_tile_width;
  logic [rbdc_pkg::SIDE_FIELD_W-1:0] in_tile_height;
  logic [rbdc_pkg::COLOR_W-1:0]      in_color;
  logic [rbdc_pkg::SIDE_W-1:0]       tw;
  logic [rbdc_pkg::SIDE_W-1:0]       th;
  logic [rbdc_pkg::SIDE_W-1:0]       col_inc;
  logic [rbdc_pkg::SIDE_W-1:0]       row_inc;

  logic [rbdc_pkg::CNT_W-1:0] column_count;
  logic [rbdc_pkg::CNT_W-1:0] column_count_next;
  logic [rbdc_pkg::CNT_W-1:0] row_count;
  logic [rbdc_pkg::CNT_W-1:0] row_count_next;

  logic                         s1_valid;
  logic [rbdc_pkg::COORD_W-1:0] s1_tile_x;
  logic [rbdc_pkg::COORD_W-1:0] s1_tile_y;
  logic [rbdc_pkg::CNT_W-1:0]   s1_col;
  logic [rbdc_pkg::CNT_W-1:0]   s1_row;
  logic [rbdc_pkg::COLOR_W-1:0] s1_color;

  logic                              accept;
  logic                              out_load;
  logic [rbdc_pkg::SUM_W-1:0]        px;
  logic [rbdc_pkg::SUM_W-1:0]        py;
  logic                              keep;
  logic [4:0]                        red;
  logic [5:0]                        green;
  logic [4:0]                        blue;
  logic [rbdc_pkg::GRAY_SUM_W-1:0]   gray_sum;
  logic [rbdc_pkg::GRAY_PROD_W-1:0]  gray_prod;
  logic [rbdc_pkg::GRAY_W-1:0]       gray;
  logic [rbdc_pkg::GRAY_W-1:0]       threshold;

  logic [rbdc_pkg::COORD_W-1:0] screen_x;
  logic [rbdc_pkg::COORD_W-1:0] screen_y;
  logic                         is_white;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = rbdc_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      rbdc_pkg::REG_TARGET_X:      prdata = rbdc_pkg::DATA_W'(target_x);
      rbdc_pkg::REG_TARGET_Y:      prdata = rbdc_pkg::DATA_W'(target_y);
      rbdc_pkg::REG_SCREEN_WIDTH:  prdata = rbdc_pkg::DATA_W'(screen_width);
      rbdc_pkg::REG_SCREEN_HEIGHT: prdata = rbdc_pkg::DATA_W'(screen_height);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x      <= rbdc_pkg::TARGET_X_RESET;
      target_y      <= rbdc_pkg::TARGET_Y_RESET;
      screen_width  <= rbdc_pkg::SCREEN_WIDTH_RESET;
      screen_height <= rbdc_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rbdc_pkg::REG_TARGET_X:      target_x      <= pwdata[rbdc_pkg::COORD_W-1:0];
        rbdc_pkg::REG_TARGET_Y:      target_y      <= pwdata[rbdc_pkg::COORD_W-1:0];
        rbdc_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[rbdc_pkg::SCREEN_W-1:0];
        rbdc_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[rbdc_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input unpack and tile counters
  assign in_tile_x      = s_tdata[10:0];
  assign in_tile_y      = s_tdata[21:11];
  assign in_tile_width  = s_tdata[30:22];
  assign in_tile_height = s_tdata[39:31];
  assign in_color       = s_tdata[55:40];

  assign tw      = rbdc_pkg::clamp_side(in_tile_width);
  assign th      = rbdc_pkg::clamp_side(in_tile_height);
  assign col_inc = {1'b0, column_count} + rbdc_pkg::SIDE_W'(1);
  assign row_inc = {1'b0, row_count} + rbdc_pkg::SIDE_W'(1);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (col_inc >= tw) begin
      column_count_next = '0;
      if (row_inc >= th) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_inc[rbdc_pkg::CNT_W-1:0];
      end
    end else begin
      column_count_next = col_inc[rbdc_pkg::CNT_W-1:0];
    end
  end

  // Handshake: the result register loads when empty or drained
  assign out_load = !m_tvalid || m_tready;
  assign s_tready = out_load || !s1_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        s1_valid     <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tile_x <= in_tile_x;
      s1_tile_y <= in_tile_y;
      s1_col    <= column_count;
      s1_row    <= row_count;
      s1_color  <= in_color;
    end
  end

  // Place, clip and dither
  assign px = rbdc_pkg::SUM_W'(target_x) + rbdc_pkg::SUM_W'(s1_tile_x)
            + rbdc_pkg::SUM_W'(s1_col);
  assign py = rbdc_pkg::SUM_W'(target_y) + rbdc_pkg::SUM_W'(s1_tile_y)
            + rbdc_pkg::SUM_W'(s1_row);
  assign keep = (px < rbdc_pkg::SUM_W'(rbdc_pkg::clamp_screen(screen_width)))
             && (py < rbdc_pkg::SUM_W'(rbdc_pkg::clamp_screen(screen_height)));

  assign red       = s1_color[15:11];
  assign green     = s1_color[10:5];
  assign blue      = s1_color[4:0];
  assign gray_sum  = rbdc_pkg::GRAY_SUM_W'({red, 3'b000})
                   + rbdc_pkg::GRAY_SUM_W'({green, 2'b00})
                   + rbdc_pkg::GRAY_SUM_W'({blue, 3'b000});
  assign gray_prod = rbdc_pkg::GRAY_PROD_W'(gray_sum) * rbdc_pkg::GRAY_PROD_W'(rbdc_pkg::GRAY_MUL);
  assign gray      = gray_prod[rbdc_pkg::GRAY_SHIFT +: rbdc_pkg::GRAY_W];
  assign threshold = rbdc_pkg::BAYER[py[1:0]][px[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= s1_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      screen_x <= px[rbdc_pkg::COORD_W-1:0];
      screen_y <= py[rbdc_pkg::COORD_W-1:0];
      is_white <= gray > threshold;
    end
  end

  assign m_tdata = {1'b0, is_white, screen_y, screen_x};

endmodule

@@ design/rbdc_checker.sv @@
// Port-level checks of the RGB565 Bayer dither and clip block, bound to its top level
`include "assert_macros.svh"

module rbdc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [rbdc_pkg::IN_W-1:0]   s_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [rbdc_pkg::OUT_W-1:0]  m_tdata,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [rbdc_pkg::ADDR_W-1:0] paddr,
  input logic [rbdc_pkg::DATA_W-1:0] pwdata,
  input logic [rbdc_pkg::DATA_W-1:0] prdata,
  input logic                        pready
);

  logic [rbdc_pkg::DATA_W-1:0] wr_mask;

  assign wr_mask = paddr[3] ? rbdc_pkg::DATA_W'(12'hFFF) : rbdc_pkg::DATA_W'(11'h7FF);

  `ASSERT_SYNC(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result request changed while stalled")
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result request right after reset")
  `ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")
  `ASSERT_SYNC(a_readback, clk, rst, psel && penable && pwrite && pready ##1 psel && !pwrite && paddr == $past(paddr) |-> prdata == ($past(pwdata) & $past(wr_mask)), "register readback differs from write")

endmodule

bind rgb565_bayer_dither_clip rbdc_checker u_rbdc_checker (.*);
